>>> rtl/core/distinct_palindromic_subsequence_count_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Same-cycle implication and next-cycle checks, empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef DISTINCT_PALINDROMIC_SUBSEQUENCE_COUNT_MACROS_SVH
`define DISTINCT_PALINDROMIC_SUBSEQUENCE_COUNT_MACROS_SVH
`ifndef SYNTH
`define DPSC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define DPSC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define DPSC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DPSC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/dpsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsc_pkg
// Shared types and constants of the palindromic subsequence counter.
// ----------------------------------------------------------------------------
package dpsc_pkg;

   localparam int SymbolW    = 8;
   localparam int SymbolCnt  = 256;
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = 2;
   localparam int QueueCntW  = 3;
   localparam int FlagsW     = 3;

   typedef struct packed {
      logic last;
      logic drop;
      logic seen_valid;
   } item_flags_type;

   typedef enum logic [2:0] {
      BK_LOAD,
      BK_CELL0,
      BK_CELL1,
      BK_CELL2,
      BK_CELL3
   } back_state_type;

endpackage

>>> rtl/core/dpsc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsc_queue
// Short FIFO between the loading front and the table-filling back.
// ----------------------------------------------------------------------------
module dpsc_queue #(
   parameter int DATA_W = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  logic [DATA_W-1:0]               wdata,
   input  logic                            pop,
   output logic [DATA_W-1:0]               rdata,
   output logic                            empty,
   output logic [dpsc_pkg::QueueCntW-1:0]  count
);

   logic [DATA_W-1:0]               slot_ff [dpsc_pkg::QueueDepth];
   logic [dpsc_pkg::QueuePtrW-1:0]  wr_ptr_ff;
   logic [dpsc_pkg::QueuePtrW-1:0]  rd_ptr_ff;
   logic [dpsc_pkg::QueueCntW-1:0]  cnt_ff;
   logic [dpsc_pkg::QueueCntW-1:0]  cnt_in;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + dpsc_pkg::QueueCntW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - dpsc_pkg::QueueCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + dpsc_pkg::QueuePtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + dpsc_pkg::QueuePtrW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata = slot_ff[rd_ptr_ff];
   assign empty = (cnt_ff == '0);
   assign count = cnt_ff;

endmodule

>>> rtl/core/dpsc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsc_front
// Accept bytes, assign positions, look up the previous occurrence of each.
// ----------------------------------------------------------------------------
module dpsc_front #(
   parameter int MAX_LEN = 256,
   parameter int PW      = 8,
   parameter int LW      = 9,
   parameter int DATA_W  = 27
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_start,
   input  logic [dpsc_pkg::SymbolW-1:0]    req_symbol,
   input  logic                            req_last,
   output logic                            busy,
   input  logic [dpsc_pkg::QueueCntW-1:0]  q_count,
   output logic                            q_push,
   output logic [DATA_W-1:0]               q_wdata
);

   logic [PW-1:0]                    seen_mem [dpsc_pkg::SymbolCnt];
   logic [dpsc_pkg::SymbolCnt-1:0]   seen_vld_ff;
   logic [LW-1:0]                    pos_ff;
   logic                             s1_valid_ff;
   logic [PW-1:0]                    s1_pos_ff;
   logic [PW-1:0]                    s1_seen_ff;
   logic [dpsc_pkg::SymbolW-1:0]     s1_sym_ff;
   dpsc_pkg::item_flags_type         s1_flags_ff;
   logic                             accept;
   logic                             drop;

   assign busy   = (int'(q_count) + int'(s1_valid_ff)) >= dpsc_pkg::QueueDepth;
   assign accept = req_start && !busy;
   assign drop   = (pos_ff == LW'(MAX_LEN));

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         seen_vld_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            if (req_last) begin
               pos_ff      <= '0;
               seen_vld_ff <= '0;
            end else if (!drop) begin
               pos_ff                  <= pos_ff + LW'(1);
               seen_vld_ff[req_symbol] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_seen_ff             <= seen_mem[req_symbol];
         s1_flags_ff.seen_valid <= seen_vld_ff[req_symbol];
         s1_flags_ff.last       <= req_last;
         s1_flags_ff.drop       <= drop;
         s1_sym_ff              <= req_symbol;
         s1_pos_ff              <= pos_ff[PW-1:0];
         if (!drop && !req_last) begin
            seen_mem[req_symbol] <= pos_ff[PW-1:0];
         end
      end
   end

   assign q_push  = s1_valid_ff;
   assign q_wdata = {s1_flags_ff, s1_sym_ff, s1_seen_ff, s1_pos_ff};

endmodule

>>> rtl/core/dpsc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsc_back
// Store the string and fill the interval table diagonal by diagonal.
// ----------------------------------------------------------------------------
`include "distinct_palindromic_subsequence_count_macros.svh"
module dpsc_back #(
   parameter int MAX_LEN = 256,
   parameter int CW      = 32,
   parameter int PW      = 8,
   parameter int LW      = 9,
   parameter int DATA_W  = 27
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  logic [DATA_W-1:0]     q_rdata,
   output logic                  q_pop,
   output logic                  rsp_valid,
   output logic [31:0]           rsp_count,
   output logic                  rsp_too_long
);

   localparam int TblDepth = 1 << (2 * PW);

   logic [dpsc_pkg::SymbolW-1:0] text_mem  [MAX_LEN];
   logic [PW:0]                  prev_mem  [MAX_LEN];
   logic [PW-1:0]                later_mem [MAX_LEN];
   logic [CW-1:0]                tbl_mem   [TblDepth];

   dpsc_pkg::back_state_type state_ff, state_in;
   dpsc_pkg::item_flags_type ent_flags;
   logic [PW-1:0]                ent_pos, ent_seen;
   logic [dpsc_pkg::SymbolW-1:0] ent_sym;

   logic [LW-1:0]   len_ff, n_ff;
   logic            ovf_ff;
   logic [PW-1:0]   g_ff, i_ff, j;
   logic            rsp_valid_ff, rsp_too_long_ff;
   logic [CW-1:0]   res_ff;

   logic [dpsc_pkg::SymbolW-1:0] text_a_q, text_b_q;
   logic [PW-1:0]   later_q;
   logic [PW:0]     prev_q;
   logic [CW-1:0]   tbl_a_q, tbl_b_q;
   logic [CW-1:0]   sum_ff, twice_ff;
   logic            eq_ff, hv_ff, empty_ff;
   logic [PW-1:0]   lo_ff, hi_ff;

   logic            ld_we, tbl_we, finish, last_col, lo_ok;
   logic [CW-1:0]   wd;
   logic [PW-1:0]   prev_ra, tbl_ra_a, tbl_ra_b, tbl_rb_a, tbl_rb_b;
   logic [CW-1:0]   twice;

   assign ent_pos   = q_rdata[PW-1:0];
   assign ent_seen  = q_rdata[2*PW-1:PW];
   assign ent_sym   = q_rdata[2*PW+dpsc_pkg::SymbolW-1:2*PW];
   assign ent_flags = dpsc_pkg::item_flags_type'(q_rdata[DATA_W-1:DATA_W-dpsc_pkg::FlagsW]);

   assign j        = i_ff + g_ff;
   assign last_col = (LW'(j) == n_ff - LW'(1));
   assign twice    = tbl_a_q << 1;
   assign lo_ok    = (lo_ff > i_ff) && (LW'(lo_ff) < n_ff) && prev_q[PW]
                     && (prev_q[PW-1:0] == i_ff);

   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      ld_we    = 1'b0;
      tbl_we   = 1'b0;
      wd       = '0;
      prev_ra  = j;
      tbl_ra_a = i_ff;
      tbl_ra_b = j - PW'(1);
      tbl_rb_a = i_ff + PW'(1);
      tbl_rb_b = j;
      unique case (state_ff)
         dpsc_pkg::BK_LOAD: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               ld_we = !ent_flags.drop;
               if (ent_flags.last) begin
                  state_in = dpsc_pkg::BK_CELL0;
               end
            end
         end
         dpsc_pkg::BK_CELL0: begin
            if (g_ff == '0) begin
               tbl_we = 1'b1;
               wd     = CW'(1);
            end else if (g_ff == PW'(1)) begin
               tbl_we = 1'b1;
               wd     = CW'(2);
            end else begin
               state_in = dpsc_pkg::BK_CELL1;
            end
         end
         dpsc_pkg::BK_CELL1: begin
            prev_ra  = later_q;
            tbl_ra_a = i_ff + PW'(1);
            state_in = dpsc_pkg::BK_CELL2;
         end
         dpsc_pkg::BK_CELL2: begin
            tbl_ra_a = lo_ff + PW'(1);
            tbl_ra_b = hi_ff - PW'(1);
            priority if (!eq_ff) begin
               tbl_we = 1'b1;
               wd     = sum_ff - tbl_a_q;
            end else if (!lo_ok || !hv_ff || (lo_ff > hi_ff)) begin
               tbl_we = 1'b1;
               wd     = twice + CW'(2);
            end else if (lo_ff == hi_ff) begin
               tbl_we = 1'b1;
               wd     = twice + CW'(1);
            end else begin
               state_in = dpsc_pkg::BK_CELL3;
            end
         end
         dpsc_pkg::BK_CELL3: begin
            tbl_we = 1'b1;
            wd     = empty_ff ? twice_ff : (twice_ff - tbl_a_q);
         end
         default: begin
            state_in = dpsc_pkg::BK_LOAD;
         end
      endcase
      finish = tbl_we && last_col && (LW'(g_ff) == n_ff - LW'(1));
      if (tbl_we) begin
         state_in = finish ? dpsc_pkg::BK_LOAD : dpsc_pkg::BK_CELL0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dpsc_pkg::BK_LOAD;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= finish;
         if (finish) begin
            len_ff <= '0;
            ovf_ff <= 1'b0;
         end else begin
            if (ld_we) begin
               len_ff <= LW'(ent_pos) + LW'(1);
            end
            if (q_pop && ent_flags.drop) begin
               ovf_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && ent_flags.last) begin
         n_ff <= ent_flags.drop ? len_ff : (LW'(ent_pos) + LW'(1));
         g_ff <= '0;
         i_ff <= '0;
      end else if (tbl_we) begin
         if (last_col) begin
            g_ff <= g_ff + PW'(1);
            i_ff <= '0;
         end else begin
            i_ff <= i_ff + PW'(1);
         end
      end
      if (state_ff == dpsc_pkg::BK_CELL1) begin
         sum_ff <= tbl_a_q + tbl_b_q;
         eq_ff  <= (text_a_q == text_b_q);
         lo_ff  <= later_q;
         hi_ff  <= prev_q[PW-1:0];
         hv_ff  <= prev_q[PW];
      end
      if (state_ff == dpsc_pkg::BK_CELL2) begin
         twice_ff <= twice;
         empty_ff <= (hi_ff == lo_ff + PW'(1));
      end
      if (tbl_we) begin
         res_ff <= wd;
      end
      if (finish) begin
         rsp_too_long_ff <= ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_we) begin
         text_mem[ent_pos] <= ent_sym;
         prev_mem[ent_pos] <= {ent_flags.seen_valid, ent_seen};
         if (ent_flags.seen_valid) begin
            later_mem[ent_seen] <= ent_pos;
         end
      end
      text_a_q <= text_mem[i_ff];
      text_b_q <= text_mem[j];
      later_q  <= later_mem[i_ff];
      prev_q   <= prev_mem[prev_ra];
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[{i_ff, j}] <= wd;
      end
      tbl_a_q <= tbl_mem[{tbl_ra_a, tbl_ra_b}];
      tbl_b_q <= tbl_mem[{tbl_rb_a, tbl_rb_b}];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_count    = 32'(res_ff);
   assign rsp_too_long = rsp_too_long_ff;

   `DPSC_ASSERT_NEXT(a_rsp_strobe, clock, reset, rsp_valid_ff, !rsp_valid_ff)
   `DPSC_ASSERT_IMP(a_fill_range, clock, reset, state_ff != dpsc_pkg::BK_LOAD, (LW'(g_ff) < n_ff) && (LW'(j) < n_ff))
   `DPSC_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid_ff, state_ff == dpsc_pkg::BK_LOAD)

endmodule

>>> rtl/core/distinct_palindromic_subsequence_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distinct_palindromic_subsequence_count
// Count distinct palindromic subsequences of a byte string.
// ----------------------------------------------------------------------------
// Bytes enter one per cycle while busy is low; req_last closes the string.
// A four-entry queue holds the first bytes of the next string while the
// table fill runs, and busy rises once that queue and the front stage
// together hold four entries, so the rest of the next string waits for
// the fill to end. On the closing byte the fill walks the n*(n+1)/2 table
// cells diagonal by diagonal through one table memory: cells on the first
// two diagonals are written straight from BK_CELL0, the others pass
// through BK_CELL0, BK_CELL1 and BK_CELL2 and some also BK_CELL3.
// The result then shows on rsp_count and rsp_too_long for exactly one cycle
// with rsp_valid high; the receiver cannot stall it, so it must be taken then.
// Bytes past MAX_LEN are dropped and set rsp_too_long.
module distinct_palindromic_subsequence_count #(
   parameter int MAX_LEN     = 256,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_start,
   output logic                          busy,
   input  logic [dpsc_pkg::SymbolW-1:0]  req_symbol,
   input  logic                          req_last,
   output logic                          rsp_valid,
   output logic [31:0]                   rsp_count,
   output logic                          rsp_too_long
);

   localparam int PW     = $clog2(MAX_LEN);
   localparam int LW     = $clog2(MAX_LEN + 1);
   localparam int DATA_W = dpsc_pkg::FlagsW + dpsc_pkg::SymbolW + 2 * PW;

   logic                            q_push, q_pop, q_empty;
   logic [DATA_W-1:0]               q_wdata, q_rdata;
   logic [dpsc_pkg::QueueCntW-1:0]  q_count;

   dpsc_front #(
      .MAX_LEN (MAX_LEN),
      .PW      (PW),
      .LW      (LW),
      .DATA_W  (DATA_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_start  (req_start),
      .req_symbol (req_symbol),
      .req_last   (req_last),
      .busy       (busy),
      .q_count    (q_count),
      .q_push     (q_push),
      .q_wdata    (q_wdata)
   );

   dpsc_queue #(
      .DATA_W (DATA_W)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty),
      .count (q_count)
   );

   dpsc_back #(
      .MAX_LEN (MAX_LEN),
      .CW      (COUNT_WIDTH),
      .PW      (PW),
      .LW      (LW),
      .DATA_W  (DATA_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_rdata      (q_rdata),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_count    (rsp_count),
      .rsp_too_long (rsp_too_long)
   );

endmodule
